/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the lock sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define PLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication whose consequent is checked on the following clock edge, outside reset
`define PLS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* hw/rtl/pls_pkg.sv */
// Types, codes and constants of the PLL lock sequencer
package pls_pkg;

  localparam int unsigned MAX_TRACKERS = 8;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_GM    = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;
  localparam logic [1:0] MODE_SLAVE = 2'd3;

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_CHANS  = 2'd1;
  localparam logic [1:0] CFG_TRKEN  = 2'd2;
  localparam logic [1:0] CFG_SETTLE = 2'd3;

  localparam logic [3:0]  CHANS_RST     = 4'd1;
  localparam logic [31:0] SETTLE_RST    = 32'd10000;
  localparam logic [14:0] DAC_FREE_MAIN = 15'd32000;

  // Numeric state codes seen on the result channel
  localparam logic [3:0] CODE_CLEAR        = 4'd0;
  localparam logic [3:0] CODE_WAIT_CLEAR   = 4'd1;
  localparam logic [3:0] CODE_START_EXT    = 4'd2;
  localparam logic [3:0] CODE_WAIT_EXT     = 4'd3;
  localparam logic [3:0] CODE_START_HELPER = 4'd4;
  localparam logic [3:0] CODE_WAIT_HELPER  = 4'd5;
  localparam logic [3:0] CODE_START_MAIN   = 4'd6;
  localparam logic [3:0] CODE_WAIT_MAIN    = 4'd7;
  localparam logic [3:0] CODE_READY        = 4'd8;
  localparam logic [3:0] CODE_DISABLED     = 4'd9;

  typedef enum logic [9:0] {
    ST_CLEAR        = 10'b00_0000_0001,
    ST_WAIT_CLEAR   = 10'b00_0000_0010,
    ST_START_EXT    = 10'b00_0000_0100,
    ST_WAIT_EXT     = 10'b00_0000_1000,
    ST_START_HELPER = 10'b00_0001_0000,
    ST_WAIT_HELPER  = 10'b00_0010_0000,
    ST_START_MAIN   = 10'b00_0100_0000,
    ST_WAIT_MAIN    = 10'b00_1000_0000,
    ST_READY        = 10'b01_0000_0000,
    ST_DISABLED     = 10'b10_0000_0000
  } sqr_state_t;

  function automatic logic [3:0] state_code(input sqr_state_t st);
    logic [3:0] code;
    unique case (st)
      ST_CLEAR:        code = CODE_CLEAR;
      ST_WAIT_CLEAR:   code = CODE_WAIT_CLEAR;
      ST_START_EXT:    code = CODE_START_EXT;
      ST_WAIT_EXT:     code = CODE_WAIT_EXT;
      ST_START_HELPER: code = CODE_START_HELPER;
      ST_WAIT_HELPER:  code = CODE_WAIT_HELPER;
      ST_START_MAIN:   code = CODE_START_MAIN;
      ST_WAIT_MAIN:    code = CODE_WAIT_MAIN;
      ST_READY:        code = CODE_READY;
      default:         code = CODE_DISABLED;
    endcase
    return code;
  endfunction

  // Trackers on channels below min(count, MAX_TRACKERS, 8) that are enabled
  function automatic logic [7:0] active_trackers(input logic [3:0] cnt,
                                                 input logic [7:0] en);
    logic [3:0] lim;
    logic [7:0] act;
    lim = (cnt > 4'(MAX_TRACKERS)) ? 4'(MAX_TRACKERS) : cnt;
    if (lim > 4'd8) lim = 4'd8;
    for (int i = 0; i < 8; i++) begin
      act[i] = en[i] && (4'(i) < lim);
    end
    return act;
  endfunction

endpackage

/* hw/rtl/pll_lock_sequencer.sv */
// Lock sequencer of a software PLL: input register, step logic, result register
// An item passes through the input register and then the result register to the out_ ports.
// Throughput: one item per cycle while out_stall does not hold the result register;
// the sequencer state loop closes between the input register and the state registers.
// Reset: synchronous, active low; clears both stages, the sequencer (disabled) and
// the configuration registers to their defaults.
`include "assert_macros.svh"

module pll_lock_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic        in_helper_lock,
  input  logic        in_external_lock,
  input  logic        in_main_lock,
  input  logic [31:0] in_now_ticks,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_seq_state_now,
  output logic        out_clear_dacs,
  output logic [14:0] out_dac_main_value,
  output logic        out_start_external,
  output logic        out_start_helper,
  output logic        out_start_main,
  output logic [7:0]  out_start_tracker_mask,
  output logic [1:0]  out_external_updates,
  output logic        out_update_helper,
  output logic        out_update_main,
  output logic [7:0]  out_update_tracker_mask,
  output logic [31:0] out_delock_total
);

  // configuration registers
  logic [1:0]  mode_r;
  logic [3:0]  chans_r;
  logic [7:0]  trk_en_r;
  logic [31:0] settle_r;

  // input stage
  logic        s1_v_r;
  logic        s1_action_r, s1_hl_r, s1_el_r, s1_ml_r;
  logic [31:0] s1_now_r;

  // sequencer state
  pls_pkg::sqr_state_t state_r, state_nxt;
  logic        hl_seen_r, hl_seen_nxt;
  logic [31:0] settle_start_r, settle_start_nxt;
  logic [31:0] delock_r, delock_nxt;
  logic [14:0] dac_def_r, dac_def_nxt;

  // result stage
  logic        out_valid_r;
  logic [3:0]  seq_code_r;
  logic        clr_r, s_ext_r, s_hlp_r, s_main_r, u_hlp_r, u_main_r;
  logic [14:0] dac_val_r;
  logic [7:0]  s_trk_r, u_trk_r;
  logic [1:0]  n_ext_r;

  // step outputs
  logic        clr_c, s_ext_c, s_hlp_c, s_main_c, u_hlp_c, u_main_c;
  logic [7:0]  s_trk_c, u_trk_c, act_trk;
  logic [1:0]  n_ext_c;
  logic [31:0] elapsed;

  logic adv_out, take_s1;

  assign adv_out  = !out_valid_r || !out_stall;
  assign take_s1  = s1_v_r && adv_out;
  assign in_stall = s1_v_r && !adv_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= pls_pkg::MODE_OFF;
      chans_r  <= pls_pkg::CHANS_RST;
      trk_en_r <= '0;
      settle_r <= pls_pkg::SETTLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pls_pkg::CFG_MODE:   mode_r   <= cfg_wdata[1:0];
        pls_pkg::CFG_CHANS:  chans_r  <= cfg_wdata[3:0];
        pls_pkg::CFG_TRKEN:  trk_en_r <= cfg_wdata[7:0];
        pls_pkg::CFG_SETTLE: settle_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action_r <= in_action;
      s1_hl_r     <= in_helper_lock;
      s1_el_r     <= in_external_lock;
      s1_ml_r     <= in_main_lock;
      s1_now_r    <= in_now_ticks;
    end
  end

  assign act_trk = pls_pkg::active_trackers(chans_r, trk_en_r);
  assign elapsed = s1_now_r - settle_start_r;

  always_comb begin
    state_nxt        = state_r;
    hl_seen_nxt      = hl_seen_r;
    settle_start_nxt = settle_start_r;
    delock_nxt       = delock_r;
    dac_def_nxt      = dac_def_r;
    clr_c    = 1'b0;
    s_ext_c  = 1'b0;
    s_hlp_c  = 1'b0;
    s_main_c = 1'b0;
    s_trk_c  = '0;
    n_ext_c  = '0;
    u_hlp_c  = 1'b0;
    u_main_c = 1'b0;
    u_trk_c  = '0;

    if (s1_action_r) begin
      state_nxt   = (mode_r == pls_pkg::MODE_OFF) ? pls_pkg::ST_DISABLED : pls_pkg::ST_CLEAR;
      hl_seen_nxt = 1'b0;
      delock_nxt  = '0;
      dac_def_nxt = (mode_r == pls_pkg::MODE_FREE) ? pls_pkg::DAC_FREE_MAIN : '0;
    end else begin
      unique case (state_r)
        pls_pkg::ST_CLEAR: begin
          clr_c            = 1'b1;
          settle_start_nxt = s1_now_r;
          state_nxt        = pls_pkg::ST_WAIT_CLEAR;
        end
        pls_pkg::ST_WAIT_CLEAR: begin
          if (elapsed > settle_r) begin
            state_nxt = (mode_r == pls_pkg::MODE_GM) ? pls_pkg::ST_START_EXT
                                                     : pls_pkg::ST_START_HELPER;
          end
        end
        pls_pkg::ST_START_EXT: begin
          n_ext_c   = 2'd1;
          s_ext_c   = 1'b1;
          state_nxt = pls_pkg::ST_WAIT_EXT;
        end
        pls_pkg::ST_WAIT_EXT: begin
          if (s1_el_r) state_nxt = pls_pkg::ST_START_HELPER;
        end
        pls_pkg::ST_START_HELPER: begin
          hl_seen_nxt = 1'b0;
          s_hlp_c     = 1'b1;
          state_nxt   = pls_pkg::ST_WAIT_HELPER;
        end
        pls_pkg::ST_WAIT_HELPER: begin
          if (s1_hl_r && !hl_seen_r) begin
            hl_seen_nxt = 1'b1;
            if (mode_r == pls_pkg::MODE_SLAVE) begin
              state_nxt = pls_pkg::ST_START_MAIN;
            end else begin
              s_trk_c   = act_trk;
              state_nxt = pls_pkg::ST_READY;
            end
          end
        end
        pls_pkg::ST_START_MAIN: begin
          s_main_c  = 1'b1;
          state_nxt = pls_pkg::ST_WAIT_MAIN;
        end
        pls_pkg::ST_WAIT_MAIN: begin
          if (s1_ml_r) begin
            state_nxt = pls_pkg::ST_READY;
            s_trk_c   = act_trk;
          end
        end
        pls_pkg::ST_READY: begin
          // drop back on loss of a lock that the mode uses and count it
          if (!s1_hl_r) begin
            state_nxt  = pls_pkg::ST_CLEAR;
            delock_nxt = delock_r + 32'd1;
          end else if (mode_r == pls_pkg::MODE_GM && !s1_el_r) begin
            state_nxt  = pls_pkg::ST_START_EXT;
            delock_nxt = delock_r + 32'd1;
          end else if (mode_r == pls_pkg::MODE_SLAVE && !s1_ml_r) begin
            state_nxt  = pls_pkg::ST_CLEAR;
            delock_nxt = delock_r + 32'd1;
          end
        end
        default: ;
      endcase

      // updaters follow the state reached by this item
      unique case (state_nxt)
        pls_pkg::ST_WAIT_EXT: begin
          n_ext_c = n_ext_c + 2'd1;
        end
        pls_pkg::ST_WAIT_HELPER: begin
          if (mode_r == pls_pkg::MODE_GM) n_ext_c = n_ext_c + 2'd1;
          u_hlp_c = 1'b1;
        end
        pls_pkg::ST_WAIT_MAIN, pls_pkg::ST_READY: begin
          u_hlp_c = 1'b1;
          if (mode_r == pls_pkg::MODE_GM) n_ext_c = n_ext_c + 2'd1;
          u_main_c = (mode_r == pls_pkg::MODE_SLAVE);
          u_trk_c  = act_trk;
        end
        default: ;
      endcase
    end
  end

  // sequencer state advances with each item that enters the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= pls_pkg::ST_DISABLED;
      hl_seen_r      <= 1'b0;
      settle_start_r <= '0;
      delock_r       <= '0;
      dac_def_r      <= '0;
    end else if (take_s1) begin
      state_r        <= state_nxt;
      hl_seen_r      <= hl_seen_nxt;
      settle_start_r <= settle_start_nxt;
      delock_r       <= delock_nxt;
      dac_def_r      <= dac_def_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take_s1) begin
      seq_code_r <= pls_pkg::state_code(state_nxt);
      clr_r      <= clr_c;
      dac_val_r  <= clr_c ? dac_def_nxt : '0;
      s_ext_r    <= s_ext_c;
      s_hlp_r    <= s_hlp_c;
      s_main_r   <= s_main_c;
      s_trk_r    <= s_trk_c;
      n_ext_r    <= n_ext_c;
      u_hlp_r    <= u_hlp_c;
      u_main_r   <= u_main_c;
      u_trk_r    <= u_trk_c;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_seq_state_now       = seq_code_r;
  assign out_clear_dacs          = clr_r;
  assign out_dac_main_value      = dac_val_r;
  assign out_start_external      = s_ext_r;
  assign out_start_helper        = s_hlp_r;
  assign out_start_main          = s_main_r;
  assign out_start_tracker_mask  = s_trk_r;
  assign out_external_updates    = n_ext_r;
  assign out_update_helper       = u_hlp_r;
  assign out_update_main         = u_main_r;
  assign out_update_tracker_mask = u_trk_r;
  assign out_delock_total        = delock_r;

  `PLS_ASSERT(a_clear_moves_to_wait,
    !(out_valid_r && clr_r) || (seq_code_r == pls_pkg::CODE_WAIT_CLEAR),
    "DAC clear issued without entering the settle wait")
  `PLS_ASSERT(a_ext_start_two_updates,
    !(out_valid_r && s_ext_r) || (n_ext_r == 2'd2),
    "external start without two external updates")
  `PLS_ASSERT_NEXT(a_held_item_stays, s1_v_r && in_stall,
    s1_v_r && $stable(s1_now_r) && $stable(s1_action_r),
    "held input item lost or changed")
  `PLS_ASSERT_NEXT(a_state_only_on_take, !take_s1,
    $stable(state_r) && $stable(delock_r),
    "sequencer state moved without an item")

endmodule
